>>> rtl/fts_pkg.sv
`default_nettype none

package fts_pkg;

  localparam int SEQ_W    = 13;
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 64;
  localparam int HDR_W    = 32;
  localparam int VER_W    = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // one sequence step in nanoseconds
  localparam int TICK_NS  = 1000000;
  localparam int TICK_W   = $clog2(TICK_NS + 1);
  localparam int SPAN_W   = SEQ_W + TICK_W;

  localparam logic [VER_W-1:0] VER_2     = 3'd2;
  localparam logic [VER_W-1:0] VER_3     = 3'd3;
  localparam logic [VER_W-1:0] VER_4     = 3'd4;
  localparam logic [VER_W-1:0] VER_RESET = VER_4;

  localparam logic [KIND_W-1:0] KIND_P = 2'd2;
  localparam logic [KIND_W-1:0] KIND_B = 2'd3;

  // register word index on the config port
  localparam logic REG_STREAM_VERSION = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic              bad;
  } hdr_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
  } apb_req_t;

endpackage

`default_nettype wire

>>> rtl/fts_cfg.sv
`default_nettype none

module fts_cfg (
  input  wire                         clk,
  input  wire                         rst_n,
  input  fts_pkg::apb_req_t           req,
  output logic [fts_pkg::APB_DW-1:0]  prdata,
  output logic [fts_pkg::VER_W-1:0]   stream_version
);
  import fts_pkg::*;

  logic [VER_W-1:0] version_r;
  logic             wr_en;

  assign wr_en = req.psel && req.penable && req.pwrite &&
                 (req.paddr[2] == REG_STREAM_VERSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VER_RESET;
    end else if (wr_en) begin
      version_r <= req.pwdata[VER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (req.paddr[2] == REG_STREAM_VERSION) begin
      prdata = {{(APB_DW-VER_W){1'b0}}, version_r};
    end
  end

  assign stream_version = version_r;

endmodule

`default_nettype wire

>>> rtl/fts_hdr_parse.sv
`default_nettype none

module fts_hdr_parse (
  input  wire [fts_pkg::HDR_W-1:0] header_word,
  input  wire [fts_pkg::VER_W-1:0] stream_version,
  output fts_pkg::hdr_t            hdr
);
  import fts_pkg::*;

  always_comb begin
    hdr = '0;
    unique case (stream_version)
      VER_2: begin
        hdr.kind = header_word[31:30];
        hdr.seq  = header_word[22:10];
      end
      VER_3: begin
        hdr.kind = header_word[28:27];
        hdr.seq  = header_word[19:7];
      end
      VER_4: begin
        hdr.kind = header_word[30:29];
        hdr.seq  = header_word[18:6];
      end
      default: begin
        hdr.bad = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/fts_reorder.sv
`default_nettype none

module fts_reorder (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         step,
  input  fts_pkg::hdr_t               hdr,
  input  wire [fts_pkg::TIME_W-1:0]   arrival_time,
  output logic [fts_pkg::TIME_W-1:0]  present_time
);
  import fts_pkg::*;

  logic [TIME_W-1:0] next_time_r, next_time_nxt;
  logic [TIME_W-1:0] last_time_r, last_time_nxt;
  logic [SEQ_W-1:0]  next_seqno_r, next_seqno_nxt;
  logic [SEQ_W-1:0]  last_seqno_r, last_seqno_nxt;

  logic              is_b;
  logic [SEQ_W-1:0]  ref_seq;
  logic [SEQ_W-1:0]  delta;
  logic [SPAN_W-1:0] span;
  logic [TIME_W-1:0] base_time;
  logic [TIME_W-1:0] time_sum;

  // one shared multiplier: b frames measure from last, p frames from next
  assign is_b      = (hdr.kind == KIND_B);
  assign ref_seq   = is_b ? last_seqno_r : next_seqno_r;
  assign base_time = is_b ? last_time_r : next_time_r;
  assign delta     = hdr.seq - ref_seq;
  assign span      = SPAN_W'(delta) * SPAN_W'(TICK_NS);
  assign time_sum  = base_time + TIME_W'(span);

  always_comb begin
    next_time_nxt  = next_time_r;
    last_time_nxt  = last_time_r;
    next_seqno_nxt = next_seqno_r;
    last_seqno_nxt = last_seqno_r;
    present_time   = '0;
    if (!hdr.bad) begin
      if (is_b) begin
        present_time = time_sum;
      end else begin
        present_time   = next_time_r;
        last_time_nxt  = next_time_r;
        last_seqno_nxt = next_seqno_r;
        next_seqno_nxt = hdr.seq;
        next_time_nxt  = (hdr.kind == KIND_P) ? time_sum : arrival_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_time_r  <= '0;
      last_time_r  <= '0;
      next_seqno_r <= '0;
      last_seqno_r <= '0;
    end else if (step) begin
      next_time_r  <= next_time_nxt;
      last_time_r  <= last_time_nxt;
      next_seqno_r <= next_seqno_nxt;
      last_seqno_r <= last_seqno_nxt;
    end
  end

  // error and b frames leave the reorder state alone
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && (hdr.bad || is_b) |=>
      $stable(next_time_r) && $stable(last_time_r) &&
      $stable(next_seqno_r) && $stable(last_seqno_r))
    else $error("reorder state moved on error or b frame");

  // an intra frame adopts its arrival time
  a_intra_take: assert property (@(posedge clk) disable iff (!rst_n)
    step && !hdr.bad && !hdr.kind[1] |=>
      next_time_r == $past(arrival_time) && last_time_r == $past(next_time_r))
    else $error("intra frame did not take arrival time");

  // the old next becomes last on every i or p frame
  a_seq_shift: assert property (@(posedge clk) disable iff (!rst_n)
    step && !hdr.bad && !is_b |=>
      last_seqno_r == $past(next_seqno_r) && next_seqno_r == $past(hdr.seq))
    else $error("sequence numbers not shifted");

endmodule

`default_nettype wire

>>> rtl/frame_timestamp_reorder_top.sv
//  channel   direction  transfer when               payload
//  in_       input      in_valid & in_ready         header_word, arrival_time
//  out_      output     out_valid & out_ready       present_time, frame_kind,
//                                                   frame_seq, bad_version
//  apb       input      psel & penable & pready     stream_version at address 0
//
//  one item per cycle sustained while out_ready stays high; an item passes the input
//  register and then the result register before out_valid rises for it
//  the reorder state is read and updated in the single stage between the two
//  registers, so consecutive frames see each other's updates without stalls
//  rst_n is synchronous; it clears the valid flags, the reorder state and sets
//  stream_version to 4
//  a stalled result holds the result register; the input register still takes
//  one more item behind it
`default_nettype none

module frame_timestamp_reorder_top (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [fts_pkg::HDR_W-1:0]    in_header_word,
  input  wire  [fts_pkg::TIME_W-1:0]   in_arrival_time,

  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [fts_pkg::TIME_W-1:0]   out_present_time,
  output logic [fts_pkg::KIND_W-1:0]   out_frame_kind,
  output logic [fts_pkg::SEQ_W-1:0]    out_frame_seq,
  output logic                         out_bad_version,

  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [fts_pkg::APB_AW-1:0]   paddr,
  input  wire  [fts_pkg::APB_DW-1:0]   pwdata,
  output logic [fts_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fts_pkg::*;

  apb_req_t          apb_req;
  logic [VER_W-1:0]  stream_version;

  logic              in_vld_r;
  logic [HDR_W-1:0]  hdr_word_r;
  logic [TIME_W-1:0] arrival_r;

  logic              out_vld_r;
  logic [TIME_W-1:0] present_r;
  logic [KIND_W-1:0] kind_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              bad_r;

  logic              advance;
  logic              step;
  logic              in_xfer;
  hdr_t              hdr;
  logic [TIME_W-1:0] present_time;

  assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                     paddr: paddr, pwdata: pwdata};
  assign pready  = 1'b1;

  fts_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (apb_req),
    .prdata         (prdata),
    .stream_version (stream_version)
  );

  // result register free or being emptied this cycle
  assign advance  = !out_vld_r || out_ready;
  assign step     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr_word_r <= in_header_word;
      arrival_r  <= in_arrival_time;
    end
    if (step) begin
      present_r <= present_time;
      kind_r    <= hdr.kind;
      seq_r     <= hdr.seq;
      bad_r     <= hdr.bad;
    end
  end

  fts_hdr_parse u_parse (
    .header_word    (hdr_word_r),
    .stream_version (stream_version),
    .hdr            (hdr)
  );

  fts_reorder u_reorder (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .hdr          (hdr),
    .arrival_time (arrival_r),
    .present_time (present_time)
  );

  assign out_valid        = out_vld_r;
  assign out_present_time = present_r;
  assign out_frame_kind   = kind_r;
  assign out_frame_seq    = seq_r;
  assign out_bad_version  = bad_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_version |->
      out_present_time == '0 && out_frame_kind == '0 && out_frame_seq == '0)
    else $error("error result carries non-zero fields");

  // a held item is never dropped while the result side is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(hdr_word_r) && $stable(arrival_r))
    else $error("input register lost an item under stall");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_vld_r)
    else $error("processed item did not reach the result register");

endmodule

`default_nettype wire
